### hw/rtl/gmn_pkg.sv
// ----------------------------------------------------------------------------
// gmn_pkg
// Types, command/status structs and constants shared by the grid mesh
// normals controller, datapath and top level.
// ----------------------------------------------------------------------------
package gmn_pkg;

    typedef struct packed {
        logic signed [15:0] vertex_x;
        logic signed [15:0] vertex_y;
        logic signed [15:0] vertex_z;
    } t_vertex;

    typedef struct packed {
        logic signed [15:0] normal_x;
        logic signed [15:0] normal_y;
        logic signed [15:0] normal_z;
        logic [15:0]        out_row;
        logic [9:0]         out_col;
        logic               degenerate;
        logic               last_of_item;
        logic               end_of_grid;
    } t_normal;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_RD2,
        ST_RD3,
        ST_LOAD,
        ST_MUL,
        ST_NORM,
        ST_SQ,
        ST_SQRT,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef enum logic [1:0] {
        RD_LEFT,
        RD_MID,
        RD_RIGHT
    } t_rd_sel;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;
    localparam logic [1:0] CFG_FLIP = 2'd2;

    localparam logic [4:0] MUL_LAST  = 5'd6;
    localparam logic [4:0] SQ_LAST   = 5'd2;
    localparam logic [4:0] SQRT_LAST = 5'd31;
    localparam logic [4:0] DIV_LAST  = 5'd15;

    typedef struct packed {
        logic    accept;
        logic    advance;
        t_rd_sel rd_sel;
        logic    cap_left;
        logic    cap_mid;
        logic    cap_right;
        logic    second;
        logic    load;
        logic    mul;
        logic    norm;
        logic    sq;
        logic    sqrt;
        logic    div;
        logic    out_load;
        logic [4:0] step;
    } t_cmd;

    typedef struct packed {
        logic row_zero;
        logic last_row;
        logic norm_done;
        logic norm_zero;
        logic out_free;
    } t_sts;

endpackage

### hw/rtl/gmn_ctrl.sv
// ----------------------------------------------------------------------------
// gmn_ctrl
// Sequencer: row store reads, cross product, normalize, square root and
// divide steps, and result hand-off for up to two normals per request.
// ----------------------------------------------------------------------------
module gmn_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  gmn_pkg::t_sts i_sts,
    output gmn_pkg::t_cmd o_cmd
);

    gmn_pkg::t_state r_state, n_state;
    logic [4:0]      r_cnt, n_cnt;
    logic            r_second, n_second;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= gmn_pkg::ST_IDLE;
            r_cnt    <= '0;
            r_second <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_second <= n_second;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_second   = r_second;
        o_cmd      = '0;
        o_cmd.rd_sel = gmn_pkg::RD_LEFT;
        o_cmd.step   = r_cnt;
        o_cmd.second = r_second;
        o_in_stall = (r_state != gmn_pkg::ST_IDLE);
        case (r_state)
            gmn_pkg::ST_IDLE: begin
                n_second = 1'b0;
                if (i_in_valid) begin
                    o_cmd.accept = 1'b1;
                    if (i_sts.row_zero) begin
                        o_cmd.advance = 1'b1;
                    end else begin
                        n_state = gmn_pkg::ST_RD0;
                    end
                end
            end
            gmn_pkg::ST_RD0: begin
                o_cmd.rd_sel = gmn_pkg::RD_LEFT;
                n_state = gmn_pkg::ST_RD1;
            end
            gmn_pkg::ST_RD1: begin
                o_cmd.cap_left = 1'b1;
                o_cmd.rd_sel   = gmn_pkg::RD_MID;
                n_state = gmn_pkg::ST_RD2;
            end
            gmn_pkg::ST_RD2: begin
                o_cmd.cap_mid = 1'b1;
                o_cmd.rd_sel  = gmn_pkg::RD_RIGHT;
                n_state = gmn_pkg::ST_RD3;
            end
            gmn_pkg::ST_RD3: begin
                o_cmd.cap_right = 1'b1;
                n_state = gmn_pkg::ST_LOAD;
            end
            gmn_pkg::ST_LOAD: begin
                o_cmd.load = 1'b1;
                n_cnt   = '0;
                n_state = gmn_pkg::ST_MUL;
            end
            gmn_pkg::ST_MUL: begin
                o_cmd.mul = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == gmn_pkg::MUL_LAST) begin
                    n_cnt   = '0;
                    n_state = gmn_pkg::ST_NORM;
                end
            end
            gmn_pkg::ST_NORM: begin
                o_cmd.norm = 1'b1;
                if (i_sts.norm_done) begin
                    n_cnt   = '0;
                    n_state = i_sts.norm_zero ? gmn_pkg::ST_OUT : gmn_pkg::ST_SQ;
                end
            end
            gmn_pkg::ST_SQ: begin
                o_cmd.sq = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == gmn_pkg::SQ_LAST) begin
                    n_cnt   = '0;
                    n_state = gmn_pkg::ST_SQRT;
                end
            end
            gmn_pkg::ST_SQRT: begin
                o_cmd.sqrt = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == gmn_pkg::SQRT_LAST) begin
                    n_cnt   = '0;
                    n_state = gmn_pkg::ST_DIV;
                end
            end
            gmn_pkg::ST_DIV: begin
                o_cmd.div = 1'b1;
                n_cnt = r_cnt + 5'd1;
                if (r_cnt == gmn_pkg::DIV_LAST) begin
                    n_cnt   = '0;
                    n_state = gmn_pkg::ST_OUT;
                end
            end
            gmn_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (!r_second && i_sts.last_row) begin
                        n_second = 1'b1;
                        n_state  = gmn_pkg::ST_LOAD;
                    end else begin
                        o_cmd.advance = 1'b1;
                        n_second = 1'b0;
                        n_state  = gmn_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = gmn_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

### hw/rtl/gmn_datapath.sv
// ----------------------------------------------------------------------------
// gmn_datapath
// Row stores (ping-pong banks), grid counters, configuration registers,
// shared multiplier, normalizer, square root and divider, output register.
// ----------------------------------------------------------------------------
module gmn_datapath #(
    parameter int MAX_COLS = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_idx,
    input  logic [15:0]        i_cfg_data,
    input  gmn_pkg::t_vertex   i_in_data,
    input  logic               i_out_stall,
    output logic               o_out_valid,
    output gmn_pkg::t_normal   o_out_data,
    input  gmn_pkg::t_cmd      i_cmd,
    output gmn_pkg::t_sts      o_sts
);

    localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int EW = (AW + 1 > 11) ? AW + 1 : 11;

    // configuration
    logic [15:0] r_rows;
    logic [10:0] r_cols;
    logic        r_flip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows <= 16'd2;
            r_cols <= 11'd2;
            r_flip <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                gmn_pkg::CFG_ROWS: r_rows <= i_cfg_data;
                gmn_pkg::CFG_COLS: r_cols <= i_cfg_data[10:0];
                gmn_pkg::CFG_FLIP: r_flip <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // counters
    logic [15:0]   r_row;
    logic [AW-1:0] r_col;
    logic          r_bank;
    logic [15:0]   rows_m1;
    logic [EW-1:0] cols_eff;
    logic          last_col, last_row;

    always_comb begin
        rows_m1 = (r_rows < 16'd2) ? 16'd1 : r_rows - 16'd1;
        if (r_cols < 11'd2) begin
            cols_eff = EW'(2);
        end else if (EW'(r_cols) > EW'(MAX_COLS)) begin
            cols_eff = EW'(MAX_COLS);
        end else begin
            cols_eff = EW'(r_cols);
        end
        last_col = EW'(r_col) >= cols_eff - EW'(1);
        last_row = r_row >= rows_m1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row  <= '0;
            r_col  <= '0;
            r_bank <= 1'b0;
        end else if (i_cmd.advance) begin
            if (last_col) begin
                r_col  <= '0;
                r_row  <= last_row ? 16'd0 : r_row + 16'd1;
                r_bank <= ~r_bank;
            end else begin
                r_col <= r_col + AW'(1);
            end
        end
    end

    // row stores: bank r_bank holds the previous row, the other the current
    logic [47:0]   mem0 [MAX_COLS];
    logic [47:0]   mem1 [MAX_COLS];
    logic [47:0]   r_q0, r_q1;
    logic [AW-1:0] prev_addr, left_addr, addr0, addr1;

    always_comb begin
        left_addr = r_col - AW'(1);
        case (i_cmd.rd_sel)
            gmn_pkg::RD_MID:   prev_addr = r_col;
            gmn_pkg::RD_RIGHT: prev_addr = r_col + AW'(1);
            default:           prev_addr = left_addr;
        endcase
        addr0 = r_bank ? left_addr : prev_addr;
        addr1 = r_bank ? prev_addr : left_addr;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && r_bank) begin
            mem0[r_col] <= i_in_data;
        end
        r_q0 <= mem0[addr0];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept && !r_bank) begin
            mem1[r_col] <= i_in_data;
        end
        r_q1 <= mem1[addr1];
    end

    // vertex window
    gmn_pkg::t_vertex r_v, r_pl, r_pm, r_pr, r_cl;
    gmn_pkg::t_vertex prev_q, cur_q;

    assign prev_q = r_bank ? r_q1 : r_q0;
    assign cur_q  = r_bank ? r_q0 : r_q1;

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_v <= i_in_data;
        end
        if (i_cmd.cap_left) begin
            r_pl <= prev_q;
            r_cl <= cur_q;
        end
        if (i_cmd.cap_mid) begin
            r_pm <= prev_q;
        end
        if (i_cmd.cap_right) begin
            r_pr <= prev_q;
        end
    end

    // edge vectors
    gmn_pkg::t_vertex vp, va, vb;
    logic signed [16:0] r_u [3];
    logic signed [16:0] r_w [3];

    always_comb begin
        if (!i_cmd.second) begin
            vp = r_pm;
            va = last_col ? r_cl : r_pr;
            vb = last_col ? r_pl : r_v;
        end else begin
            vp = r_v;
            va = last_col ? r_cl : r_pm;
            vb = last_col ? r_pm : r_pr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_u[0] <= {va.vertex_x[15], va.vertex_x} - {vp.vertex_x[15], vp.vertex_x};
            r_u[1] <= {va.vertex_y[15], va.vertex_y} - {vp.vertex_y[15], vp.vertex_y};
            r_u[2] <= {va.vertex_z[15], va.vertex_z} - {vp.vertex_z[15], vp.vertex_z};
            r_w[0] <= {vb.vertex_x[15], vb.vertex_x} - {vp.vertex_x[15], vp.vertex_x};
            r_w[1] <= {vb.vertex_y[15], vb.vertex_y} - {vp.vertex_y[15], vp.vertex_y};
            r_w[2] <= {vb.vertex_z[15], vb.vertex_z} - {vp.vertex_z[15], vp.vertex_z};
        end
    end

    // cross product on one shared multiplier
    logic signed [16:0] ma, mb;
    logic signed [33:0] prod;
    logic signed [35:0] r_c [3];
    logic [34:0]        r_m [3];
    logic [2:0]         r_neg;
    logic [1:0]         cidx;

    always_comb begin
        case (i_cmd.step[2:0])
            3'd0:    begin ma = r_u[1]; mb = r_w[2]; end
            3'd1:    begin ma = r_u[2]; mb = r_w[1]; end
            3'd2:    begin ma = r_u[2]; mb = r_w[0]; end
            3'd3:    begin ma = r_u[0]; mb = r_w[2]; end
            3'd4:    begin ma = r_u[0]; mb = r_w[1]; end
            default: begin ma = r_u[1]; mb = r_w[0]; end
        endcase
        prod = ma * mb;
        cidx = i_cmd.step[2:1];
    end

    // normalizer status
    logic [34:0] mx;
    logic        mx_zero, mx_high, mx_ok;

    always_comb begin
        mx = r_m[0];
        if (r_m[1] > mx) mx = r_m[1];
        if (r_m[2] > mx) mx = r_m[2];
        mx_zero = (mx == '0);
        mx_high = (mx[34:30] != '0);
        mx_ok   = !mx_high && mx[29];
    end

    // square sum, root, divide
    logic [29:0] sqm;
    logic [59:0] sq;
    logic [63:0] r_s, r_root, r_bit, trial;
    logic [31:0] dv;
    logic [14:0] r_lo;
    logic [32:0] r_rem [3];
    logic [14:0] r_qt  [3];
    logic        r_degen;

    always_comb begin
        case (i_cmd.step[1:0])
            2'd0:    sqm = r_m[0][29:0];
            2'd1:    sqm = r_m[1][29:0];
            default: sqm = r_m[2][29:0];
        endcase
        sq    = sqm * sqm;
        trial = r_root + r_bit;
        dv    = {r_root[30:0], 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mul) begin
            if (i_cmd.step == gmn_pkg::MUL_LAST) begin
                for (int i = 0; i < 3; i++) begin
                    r_m[i]   <= r_c[i][35] ? 35'(-r_c[i]) : 35'(r_c[i]);
                    r_neg[i] <= r_c[i][35];
                end
            end else if (i_cmd.step[0]) begin
                r_c[cidx] <= r_c[cidx] - 36'(prod);
            end else begin
                r_c[cidx] <= 36'(prod);
            end
        end
        if (i_cmd.norm) begin
            r_degen <= mx_zero;
            if (!mx_zero && mx_high) begin
                for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] >> 1;
            end else if (!mx_zero && !mx_ok) begin
                for (int i = 0; i < 3; i++) r_m[i] <= r_m[i] << 1;
            end
        end
        if (i_cmd.sq) begin
            if (i_cmd.step == '0) begin
                r_s    <= 64'(sq);
                r_root <= '0;
                r_bit  <= 64'd1 << 62;
            end else begin
                r_s <= r_s + 64'(sq);
            end
        end
        if (i_cmd.sqrt) begin
            if (r_s >= trial) begin
                r_s    <= r_s - trial;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.div) begin
            if (i_cmd.step == '0) begin
                for (int i = 0; i < 3; i++) begin
                    r_rem[i] <= 33'(r_m[i]) + 33'(r_root[30:15]);
                    r_qt[i]  <= '0;
                end
                r_lo <= r_root[14:0];
            end else begin
                for (int i = 0; i < 3; i++) begin
                    if ({r_rem[i][31:0], r_lo[14]} >= 33'(dv)) begin
                        r_rem[i] <= {r_rem[i][31:0], r_lo[14]} - 33'(dv);
                        r_qt[i]  <= {r_qt[i][13:0], 1'b1};
                    end else begin
                        r_rem[i] <= {r_rem[i][31:0], r_lo[14]};
                        r_qt[i]  <= {r_qt[i][13:0], 1'b0};
                    end
                end
                r_lo <= {r_lo[13:0], 1'b0};
            end
        end
    end

    // result register
    gmn_pkg::t_normal n_res;
    gmn_pkg::t_normal r_out;
    logic             r_out_valid;
    logic [15:0]      nv [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_degen) begin
                nv[i] = '0;
            end else if (r_neg[i] ^ r_flip) begin
                nv[i] = -16'(r_qt[i]);
            end else begin
                nv[i] = 16'(r_qt[i]);
            end
        end
        n_res.normal_x     = nv[0];
        n_res.normal_y     = nv[1];
        n_res.normal_z     = nv[2];
        n_res.out_row      = i_cmd.second ? r_row : r_row - 16'd1;
        n_res.out_col      = 10'(r_col);
        n_res.degenerate   = r_degen;
        n_res.last_of_item = i_cmd.second || !last_row;
        n_res.end_of_grid  = i_cmd.second && last_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out <= n_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    assign o_sts.row_zero  = (r_row == '0);
    assign o_sts.last_row  = last_row;
    assign o_sts.norm_done = mx_zero || mx_ok;
    assign o_sts.norm_zero = mx_zero;
    assign o_sts.out_free  = !r_out_valid || !i_out_stall;

endmodule

### hw/rtl/grid_mesh_normals_unit.sv
// ----------------------------------------------------------------------------
// grid_mesh_normals_unit
// Per-vertex unit normals of a rows-by-columns surface grid.
//
// Vertices come in raster order on the input request channel (valid/stall).
// Row 0 vertices only fill the row store and leave the block idle. From row 1
// on, each request yields the normal of the vertex above it; in the last row
// it yields a second normal, for itself. Normals leave on the output channel
// with row, column, degenerate, last_of_item and end_of_grid flags.
// Each normal goes through row store reads, a load, seven steps on the
// shared 17x17 multiplier, a normalizing step per bit of shift plus one and,
// unless the cross product is zero, three squares, 32 root steps and 16
// divide steps. The second normal of a last-row request repeats the steps
// from the load on. One request is worked at a time; the next is taken the
// cycle after its last normal is loaded. A finished normal waits in the
// output register while the next request is taken; a stalled receiver holds
// the block before loading the next normal. Reset (synchronous, active low)
// clears counters and handshake state and sets rows=2, cols=2, no flip. The
// user must write configuration only while idle; the block does not check it.
// ----------------------------------------------------------------------------
module grid_mesh_normals_unit #(
    parameter int MAX_COLS = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [15:0]      i_cfg_data,
    input  logic             i_in_valid,
    output logic             o_in_stall,
    input  gmn_pkg::t_vertex i_in_data,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output gmn_pkg::t_normal o_out_data
);

    gmn_pkg::t_cmd cmd;
    gmn_pkg::t_sts sts;

    gmn_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    gmn_datapath #(
        .MAX_COLS (MAX_COLS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (i_in_data),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

### dv/grid_mesh_normals_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_mesh_normals_unit_tb
// Streams vertex grids of several shapes through the normals unit and checks
// each normal against a cycle-free predictor of the cross product, the
// fixed-point normalization and the row/column bookkeeping.
// ----------------------------------------------------------------------------
module grid_mesh_normals_unit_tb;

    localparam int NCOLS = 1024;
    localparam longint CYCLE_LIMIT = 64'd4000000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_cfg_we;
    logic [1:0] i_cfg_idx;
    logic [15:0] i_cfg_data;
    logic     i_in_valid;
    logic     o_in_stall;
    gmn_pkg::t_vertex  i_in_data;
    logic     o_out_valid;
    logic     i_out_stall;
    gmn_pkg::t_normal  o_out_data;

    grid_mesh_normals_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid), .o_in_stall(o_in_stall), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_stall(i_out_stall),
        .o_out_data(o_out_data)
    );

    always begin
        i_clk = 1'b1; #1;
        i_clk = 1'b0; #1;
    end

    // predictor state
    gmn_pkg::t_vertex    prev_row [NCOLS];
    gmn_pkg::t_vertex    cur_row  [NCOLS];
    int unsigned row_cnt, col_cnt;
    int unsigned cfg_rows, cfg_cols;
    bit         cfg_flip;
    gmn_pkg::t_normal    normals_due[$];

    int         errors;
    longint     cycles;
    int         send_idle_pct, recv_idle_pct;
    bit         hold_off;
    int         hold_cycles;

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("mismatch %s: got %0h expected %0h at cycle %0d", what, got, want,
                 cycles);
        errors++;
    endtask

    function automatic longint unsigned int_sqrt(input longint unsigned s);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > s) b >>= 2;
        while (b != 0) begin
            if (s >= r + b) begin
                s -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic gmn_pkg::t_normal unit_normal(input gmn_pkg::t_vertex p,
                                                     input gmn_pkg::t_vertex a,
                                                     input gmn_pkg::t_vertex b,
                                                     input int unsigned row,
                                                     input int unsigned col,
                                                     input bit eog);
        longint ux, uy, uz, vx, vy, vz, q;
        longint c[3];
        longint unsigned m[3], mx, s, r;
        longint n[3];
        gmn_pkg::t_normal o;
        ux = a.vertex_x - p.vertex_x; uy = a.vertex_y - p.vertex_y;
        uz = a.vertex_z - p.vertex_z;
        vx = b.vertex_x - p.vertex_x; vy = b.vertex_y - p.vertex_y;
        vz = b.vertex_z - p.vertex_z;
        c[0] = uy * vz - uz * vy;
        c[1] = uz * vx - ux * vz;
        c[2] = ux * vy - uy * vx;
        mx = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i] < 0 ? -c[i] : c[i];
            if (m[i] > mx) mx = m[i];
            n[i] = 0;
        end
        if (mx != 0) begin
            while (mx >= (64'd1 << 30)) begin
                mx >>= 1; m[0] >>= 1; m[1] >>= 1; m[2] >>= 1;
            end
            while (mx < (64'd1 << 29)) begin
                mx <<= 1; m[0] <<= 1; m[1] <<= 1; m[2] <<= 1;
            end
            s = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            r = int_sqrt(s);
            for (int i = 0; i < 3; i++) begin
                q = ((m[i] << 15) + r) / (2 * r);
                n[i] = ((c[i] < 0) != cfg_flip) ? -q : q;
            end
        end
        o.normal_x = n[0][15:0];
        o.normal_y = n[1][15:0];
        o.normal_z = n[2][15:0];
        o.out_row = row[15:0];
        o.out_col = col[9:0];
        o.degenerate = (mx == 0);
        o.last_of_item = 1'b0;
        o.end_of_grid = eog;
        return o;
    endfunction

    function automatic gmn_pkg::t_vertex row_at(input bit from_cur,
                                                input int unsigned idx);
        gmn_pkg::t_vertex z;
        z = '0;
        if (idx >= NCOLS) return z;
        return from_cur ? cur_row[idx] : prev_row[idx];
    endfunction

    task automatic predict_vertex(input gmn_pkg::t_vertex v);
        int unsigned rows, cols, r, c;
        bit lc, lr;
        gmn_pkg::t_normal a, b;
        rows = cfg_rows < 2 ? 2 : cfg_rows;
        cols = cfg_cols < 2 ? 2 : (cfg_cols > NCOLS ? NCOLS : cfg_cols);
        r = row_cnt;
        c = col_cnt;
        lc = c >= cols - 1;
        lr = r >= rows - 1;
        if (c < NCOLS) cur_row[c] = v;
        if (r >= 1) begin
            if (lc)
                a = unit_normal(row_at(0, c), row_at(1, c - 1), row_at(0, c - 1),
                                r - 1, c, 1'b0);
            else
                a = unit_normal(row_at(0, c), row_at(0, c + 1), v, r - 1, c, 1'b0);
            if (lr) begin
                if (lc)
                    b = unit_normal(v, row_at(1, c - 1), row_at(0, c), r, c, 1'b1);
                else
                    b = unit_normal(v, row_at(0, c), row_at(0, c + 1), r, c, 1'b0);
                b.last_of_item = 1'b1;
                normals_due = {normals_due, a};
                normals_due = {normals_due, b};
            end else begin
                a.last_of_item = 1'b1;
                normals_due = {normals_due, a};
            end
        end
        if (lc) begin
            prev_row = cur_row;
            col_cnt = 0;
            row_cnt = lr ? 0 : ((r + 1) & 16'hFFFF);
        end else begin
            col_cnt = (c + 1) & 10'h3FF;
        end
    endtask

    // sends one vertex, waits for it to be taken
    task automatic send_vertex(input gmn_pkg::t_vertex v);
        while (($urandom_range(99) < send_idle_pct)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= v;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predict_vertex(v);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (normals_due.size() != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input int unsigned val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val[15:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            gmn_pkg::CFG_ROWS: cfg_rows = val & 16'hFFFF;
            gmn_pkg::CFG_COLS: cfg_cols = val & 11'h7FF;
            default:           cfg_flip = val[0];
        endcase
    endtask

    task automatic set_grid(input int unsigned rows, input int unsigned cols,
                            input bit flip);
        write_reg(gmn_pkg::CFG_ROWS, rows);
        write_reg(gmn_pkg::CFG_COLS, cols);
        write_reg(gmn_pkg::CFG_FLIP, flip);
    endtask

    function automatic gmn_pkg::t_vertex rand_vertex();
        gmn_pkg::t_vertex v;
        v.vertex_x = 16'($urandom);
        v.vertex_y = 16'($urandom);
        v.vertex_z = 16'($urandom);
        return v;
    endfunction

    // a smooth surface with random jitter, mostly well-conditioned
    function automatic gmn_pkg::t_vertex surface_vertex(input int r, input int c);
        gmn_pkg::t_vertex v;
        v.vertex_x = 16'(c * 256 + $signed($urandom_range(63)) - 32);
        v.vertex_y = 16'(r * 256 + $signed($urandom_range(63)) - 32);
        v.vertex_z = 16'($urandom_range(2047) - 1024);
        return v;
    endfunction

    task automatic send_grid(input int rows, input int cols, input int noise_pct);
        for (int r = 0; r < rows; r++)
            for (int c = 0; c < cols; c++)
                send_vertex($urandom_range(99) < noise_pct ? rand_vertex()
                                                           : surface_vertex(r, c));
    endtask

    task automatic test_directed();
        gmn_pkg::t_vertex v;
        // flat grid: degenerate normals everywhere
        set_grid(2, 2, 0);
        for (int i = 0; i < 4; i++) send_vertex('0);
        drain();
        // extremes of coordinates
        set_grid(3, 3, 1);
        for (int i = 0; i < 9; i++) begin
            v.vertex_x = (i % 2) ? 16'sh7FFF : 16'sh8000;
            v.vertex_y = (i % 3 == 0) ? 16'sh8000 : 16'sh7FFF;
            v.vertex_z = (i % 4 < 2) ? 16'sh7FFF : 16'sh8000;
            send_vertex(v);
        end
        drain();
        // grid_rows and grid_cols below 2 act as 2
        set_grid(0, 1, 0);
        for (int i = 0; i < 4; i++) send_vertex(rand_vertex());
        drain();
        set_grid(2, 0, 1);
        for (int i = 0; i < 4; i++) send_vertex(rand_vertex());
        drain();
    endtask

    task automatic test_shapes();
        int shape_r[6] = '{2, 4, 3, 7, 2, 5};
        int shape_c[6] = '{5, 2, 9, 6, 17, 4};
        for (int k = 0; k < 6; k++) begin
            set_grid(shape_r[k], shape_c[k], k[0]);
            send_grid(shape_r[k], shape_c[k], 15);
            drain();
        end
    endtask

    task automatic test_random_grids(input int n_items);
        int sent, rows, cols;
        sent = 0;
        while (sent < n_items) begin
            rows = $urandom_range(2, 8);
            cols = $urandom_range(2, 12);
            set_grid(rows, cols, $urandom_range(1));
            send_grid(rows, cols, 20);
            sent += rows * cols;
            drain();
        end
    endtask

    task automatic test_wide_grids();
        // long rows through the row store
        set_grid(2, 160, 1);
        send_grid(2, 160, 10);
        drain();
        // tall rows setting, partial grid finished by shrinking rows
        set_grid(65535, 3, 0);
        send_grid(4, 3, 10);
        drain();
        write_reg(gmn_pkg::CFG_ROWS, 5);
        send_grid(1, 3, 10);
        drain();
    endtask

    task automatic test_backpressure();
        set_grid(6, 6, 0);
        hold_cycles = 3000;
        hold_off = 1'b1;
        send_grid(6, 6, 10);
        drain();
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (hold_off && hold_cycles > 0) begin
                hold_cycles--;
                i_out_stall <= 1'b1;
                if (hold_cycles == 0) hold_off = 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < recv_idle_pct);
            end
            if (o_out_valid && !i_out_stall) begin
                if (normals_due.size() == 0) begin
                    report("unexpected normal", o_out_data.out_col, 0);
                end else begin
                    gmn_pkg::t_normal w;
                    w = normals_due.pop_front();
                    if (o_out_data.normal_x !== w.normal_x)
                        report("normal_x", o_out_data.normal_x, w.normal_x);
                    if (o_out_data.normal_y !== w.normal_y)
                        report("normal_y", o_out_data.normal_y, w.normal_y);
                    if (o_out_data.normal_z !== w.normal_z)
                        report("normal_z", o_out_data.normal_z, w.normal_z);
                    if (o_out_data.out_row !== w.out_row)
                        report("out_row", o_out_data.out_row, w.out_row);
                    if (o_out_data.out_col !== w.out_col)
                        report("out_col", o_out_data.out_col, w.out_col);
                    if (o_out_data.degenerate !== w.degenerate)
                        report("degenerate", o_out_data.degenerate, w.degenerate);
                    if (o_out_data.last_of_item !== w.last_of_item)
                        report("last_of_item", o_out_data.last_of_item,
                               w.last_of_item);
                    if (o_out_data.end_of_grid !== w.end_of_grid)
                        report("end_of_grid", o_out_data.end_of_grid, w.end_of_grid);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        errors = 0;
        cycles = 0;
        hold_off = 1'b0;
        hold_cycles = 0;
        send_idle_pct = 17;
        recv_idle_pct = 84;
        row_cnt = 0;
        col_cnt = 0;
        cfg_rows = 2;
        cfg_cols = 2;
        cfg_flip = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = gmn_pkg::CFG_ROWS;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_shapes();
        test_random_grids(300);
        send_idle_pct = 84;
        recv_idle_pct = 17;
        test_random_grids(250);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_wide_grids();
        test_random_grids(300);

        drain();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### filelist.f
hw/rtl/gmn_pkg.sv
hw/rtl/gmn_ctrl.sv
hw/rtl/gmn_datapath.sv
hw/rtl/grid_mesh_normals_unit.sv
dv/grid_mesh_normals_unit_tb.sv
